// ===== design/rgbhsv_pkg.sv =====
// Shared types, constants and the divide step for the RGB to HSV pixel pipeline.
package rgbhsv_pkg;

   localparam int unsigned PIX_W     = 8;   // width of every channel and result field
   localparam int unsigned REM_W     = 16;  // partial remainder width (255 * 255 fits)
   localparam int unsigned QUO_W     = 8;   // quotient bits produced per division
   localparam int unsigned BITS_STG  = 2;   // quotient bits resolved per pipeline stage
   localparam int unsigned DIV_STG   = QUO_W / BITS_STG;
   localparam int unsigned BIT_IDX_W = $clog2(QUO_W);

   // hue bases in two-degree units
   localparam logic [PIX_W-1:0] HUE_BASE_RED      = 8'd0;
   localparam logic [PIX_W-1:0] HUE_BASE_RED_WRAP = 8'd180;
   localparam logic [PIX_W-1:0] HUE_BASE_GREEN    = 8'd60;
   localparam logic [PIX_W-1:0] HUE_BASE_BLUE     = 8'd120;

   // one restoring division in flight
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [PIX_W-1:0] divisor;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

   // per-pixel data that rides alongside the divisions
   typedef struct packed {
      logic             gray;      // max equals min: hue and saturation are zero
      logic             neg;       // hue offset is subtracted from the base
      logic [PIX_W-1:0] hue_base;
      logic [PIX_W-1:0] bright;
   } pix_side_type;

   // one quotient bit: subtract divisor << bit_idx when it fits
   function automatic div_lane_type div_bit(div_lane_type x, logic [BIT_IDX_W-1:0] bit_idx);
      logic [REM_W-1:0] shifted;
      div_lane_type     y;
      y       = x;
      shifted = REM_W'(x.divisor) << bit_idx;
      if (x.rem >= shifted) begin
         y.rem          = x.rem - shifted;
         y.quo[bit_idx] = 1'b1;
      end
      return y;
   endfunction

endpackage

// ===== design/rgb_to_hsv_pixel_top.sv =====
// Top level of the 8-bit RGB to HSV pixel converter pipeline.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_blue, req_green, req_red (8b each)
//   rsp_     out        rsp_valid/rsp_stall  rsp_hue, rsp_saturation, rsp_brightness
//
// One pixel per clock is accepted unless rsp_stall holds the pipeline. The two 8-bit
// quotients (saturation, hue offset) are resolved by a restoring divider at two bits
// per stage over four stages, between the stage 2 and output registers.
// Synchronous active-high reset clears only the stage valid bits.
// The whole pipeline holds while a result sits in the output register under rsp_stall;
// otherwise every stage advances each cycle, so nothing is lost or repeated.
module rgb_to_hsv_pixel_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_blue,
   input  logic [7:0] req_green,
   input  logic [7:0] req_red,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_hue,
   output logic [7:0] rsp_saturation,
   output logic [7:0] rsp_brightness
);

   localparam int unsigned W = rgbhsv_pkg::PIX_W;

   logic advance;
   logic rsp_valid_ff;

   // output register is free, or being drained this cycle
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // ---------------- stage 1: max, min, branch pick ----------------
   logic         s1_valid_ff;
   rgbhsv_pkg::pix_side_type s1_side_ff, s1_side_in;
   logic [W-1:0] s1_chroma_ff, s1_chroma_in;  // max - min
   logic [W-1:0] s1_k_ff, s1_k_in;            // |p - q| of the hue branch

   logic [W-1:0] mx, mn, p, q;
   logic [W-1:0] base;
   logic         red_branch;

   always_comb begin
      mx = (req_blue > req_green) ? req_blue : req_green;
      mx = (mx > req_red) ? mx : req_red;
      mn = (req_blue < req_green) ? req_blue : req_green;
      mn = (mn < req_red) ? mn : req_red;

      // ties: red first, then green, then blue
      red_branch = 1'b0;
      priority if (mx == req_red) begin
         red_branch = 1'b1;
         p    = req_green;
         q    = req_blue;
         base = rgbhsv_pkg::HUE_BASE_RED;
      end else if (mx == req_green) begin
         p    = req_blue;
         q    = req_red;
         base = rgbhsv_pkg::HUE_BASE_GREEN;
      end else begin
         p    = req_red;
         q    = req_green;
         base = rgbhsv_pkg::HUE_BASE_BLUE;
      end

      s1_chroma_in        = mx - mn;
      s1_side_in.gray     = (mx == mn);
      s1_side_in.neg      = (p < q);
      s1_side_in.bright   = mx;
      s1_k_in             = s1_side_in.neg ? (q - p) : (p - q);
      // negative red hue wraps by 360 degrees
      s1_side_in.hue_base = (red_branch && s1_side_in.neg) ?
                            rgbhsv_pkg::HUE_BASE_RED_WRAP : base;
   end

   // ---------------- stage 2: numerators ----------------
   // saturation = floor(255*chroma / max); hue offset = 30*k / chroma
   logic         s2_valid_ff;
   rgbhsv_pkg::pix_side_type s2_side_ff;
   rgbhsv_pkg::div_lane_type s2_sat_ff, s2_sat_in;
   rgbhsv_pkg::div_lane_type s2_hue_ff, s2_hue_in;

   always_comb begin
      s2_sat_in.rem     = (rgbhsv_pkg::REM_W'(s1_chroma_ff) << W)
                          - rgbhsv_pkg::REM_W'(s1_chroma_ff);
      s2_sat_in.divisor = s1_side_ff.bright;
      s2_sat_in.quo     = '0;
      s2_hue_in.rem     = (rgbhsv_pkg::REM_W'(s1_k_ff) << 5)
                          - (rgbhsv_pkg::REM_W'(s1_k_ff) << 1);
      s2_hue_in.divisor = s1_chroma_ff;
      s2_hue_in.quo     = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_side_ff   <= s1_side_in;
         s1_chroma_ff <= s1_chroma_in;
         s1_k_ff      <= s1_k_in;
         s2_side_ff   <= s1_side_ff;
         s2_sat_ff    <= s2_sat_in;
         s2_hue_ff    <= s2_hue_in;
      end
   end

   // ---------------- stages 3..6: division ----------------
   logic                     dv_valid;
   rgbhsv_pkg::pix_side_type dv_side;
   rgbhsv_pkg::div_lane_type dv_sat;
   rgbhsv_pkg::div_lane_type dv_hue;

   rgbhsv_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s2_valid_ff),
      .in_side   (s2_side_ff),
      .in_sat    (s2_sat_ff),
      .in_hue    (s2_hue_ff),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_sat   (dv_sat),
      .out_hue   (dv_hue)
   );

   // ---------------- stage 7: hue assembly, output register ----------------
   logic [W-1:0] hue_ff, hue_in;
   logic [W-1:0] sat_ff, sat_in;
   logic [W-1:0] bright_ff;
   logic [W-1:0] round_up;

   always_comb begin
      // subtracting a ceiling: one more when the division left a remainder
      round_up = W'(dv_hue.rem != '0);
      if (dv_side.gray) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = dv_side.neg ? (dv_side.hue_base - dv_hue.quo - round_up)
                              : (dv_side.hue_base + dv_hue.quo);
         sat_in = dv_sat.quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= dv_side.bright;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bright_ff;

endmodule

// ===== design/rgbhsv_div_pipe.sv =====
// Pipelined restoring divider: saturation and hue quotients, two bits per stage.
module rgbhsv_div_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       in_valid,
   input  rgbhsv_pkg::pix_side_type   in_side,
   input  rgbhsv_pkg::div_lane_type   in_sat,
   input  rgbhsv_pkg::div_lane_type   in_hue,
   output logic                       out_valid,
   output rgbhsv_pkg::pix_side_type   out_side,
   output rgbhsv_pkg::div_lane_type   out_sat,
   output rgbhsv_pkg::div_lane_type   out_hue
);

   logic                     valid_ff [rgbhsv_pkg::DIV_STG];
   rgbhsv_pkg::pix_side_type side_ff  [rgbhsv_pkg::DIV_STG];
   rgbhsv_pkg::div_lane_type sat_ff   [rgbhsv_pkg::DIV_STG];
   rgbhsv_pkg::div_lane_type hue_ff   [rgbhsv_pkg::DIV_STG];

   for (genvar s = 0; s < rgbhsv_pkg::DIV_STG; s++) begin : g_stage
      logic                     valid_in;
      rgbhsv_pkg::pix_side_type side_in;
      rgbhsv_pkg::div_lane_type sat_src;
      rgbhsv_pkg::div_lane_type hue_src;
      rgbhsv_pkg::div_lane_type sat_in;
      rgbhsv_pkg::div_lane_type hue_in;

      if (s == 0) begin : g_first
         assign valid_in = in_valid;
         assign side_in  = in_side;
         assign sat_src  = in_sat;
         assign hue_src  = in_hue;
      end else begin : g_next
         assign valid_in = valid_ff[s-1];
         assign side_in  = side_ff[s-1];
         assign sat_src  = sat_ff[s-1];
         assign hue_src  = hue_ff[s-1];
      end

      // high quotient bits first
      always_comb begin
         sat_in = sat_src;
         hue_in = hue_src;
         for (int j = 0; j < rgbhsv_pkg::BITS_STG; j++) begin
            sat_in = rgbhsv_pkg::div_bit(sat_in, rgbhsv_pkg::BIT_IDX_W'(
               rgbhsv_pkg::QUO_W - 1 - rgbhsv_pkg::BITS_STG * s - j));
            hue_in = rgbhsv_pkg::div_bit(hue_in, rgbhsv_pkg::BIT_IDX_W'(
               rgbhsv_pkg::QUO_W - 1 - rgbhsv_pkg::BITS_STG * s - j));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            side_ff[s] <= side_in;
            sat_ff[s]  <= sat_in;
            hue_ff[s]  <= hue_in;
         end
      end
   end

   assign out_valid = valid_ff[rgbhsv_pkg::DIV_STG-1];
   assign out_side  = side_ff[rgbhsv_pkg::DIV_STG-1];
   assign out_sat   = sat_ff[rgbhsv_pkg::DIV_STG-1];
   assign out_hue   = hue_ff[rgbhsv_pkg::DIV_STG-1];

endmodule
